// ----- hw/rtl/ssrp_pkg.sv -----
// ----------------------------------------------------------------------------
// ssrp_pkg
// Shared constants of the sphere slice radical point unit.
// ----------------------------------------------------------------------------
package ssrp_pkg;

	localparam int FIELD_W = 16;
	localparam int DZ_W    = 16;
	localparam int KK_W    = 33;
	localparam int OUT_W   = 32;

	localparam logic [FIELD_W-1:0] MAX_HEIGHT_RST = 16'd255;
	localparam logic [OUT_W-1:0]   SAT_MAX        = 32'h7fff_ffff;
	localparam logic [OUT_W-1:0]   SAT_MIN        = 32'h8000_0000;

endpackage

// ----- hw/rtl/sphere_slice_radical_point_unit.sv -----
// ----------------------------------------------------------------------------
// sphere_slice_radical_point_unit
// Radical line crossing point of two sphere slices, fully pipelined.
// ----------------------------------------------------------------------------
// Takes one seed pair per cycle (busy never rises) and returns each result
// as a one-cycle done strobe that cannot be held off. Each pair passes five
// stages of subtract, square, sum, split multiply and dividend assembly,
// then the row of restoring division cells, one quotient bit per cell (34
// up to 16, COORD_BITS*2 + 2 above), and then one output register.
module sphere_slice_radical_point_unit #(
	parameter int COORD_BITS = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [ssrp_pkg::FIELD_W-1:0]      cfg_data,
	input  logic                              start,
	output logic                              busy,
	input  logic [ssrp_pkg::FIELD_W-1:0]      layer,
	input  logic signed [ssrp_pkg::FIELD_W-1:0] first_x,
	input  logic signed [ssrp_pkg::FIELD_W-1:0] first_y,
	input  logic [ssrp_pkg::FIELD_W-1:0]      first_z,
	input  logic signed [ssrp_pkg::FIELD_W-1:0] second_x,
	input  logic signed [ssrp_pkg::FIELD_W-1:0] second_y,
	input  logic [ssrp_pkg::FIELD_W-1:0]      second_z,
	output logic                              done,
	output logic signed [ssrp_pkg::OUT_W-1:0] cross_x,
	output logic signed [ssrp_pkg::OUT_W-1:0] cross_y,
	output logic                              coincident
);

	localparam int CB   = COORD_BITS;
	localparam int D2W  = 2*CB + 1;
	localparam int DW   = 2*CB + 2;
	localparam int NMAX = (D2W > 33) ? D2W : 33;
	localparam int NW   = NMAX + 2;
	localparam int MW   = NW - 1;
	localparam int QW   = MW;
	localparam int LO   = (MW + 1) / 2;
	localparam int HI   = MW - LO;
	localparam int PW   = DW + QW;
	localparam int SW   = QW + 2;
	localparam int LAT  = QW + 6;
	localparam int ZW   = 18;
	localparam int DZ   = ssrp_pkg::DZ_W;

	localparam logic signed [SW-1:0] SMAX = SW'($signed({1'b0, ssrp_pkg::SAT_MAX}));
	localparam logic signed [SW-1:0] SMIN = SW'($signed(ssrp_pkg::SAT_MIN));

	logic [ssrp_pkg::FIELD_W-1:0] max_height_q;

	assign cfg_ready = 1'b1;
	assign busy      = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_height_q <= ssrp_pkg::MAX_HEIGHT_RST;
		end else if (cfg_valid && cfg_ready) begin
			max_height_q <= cfg_data;
		end
	end

	// stage 1: coordinate deltas
	logic signed [CB-1:0] ax, ay, bx, by;
	logic signed [CB:0]   dx, dy;
	logic signed [ZW-1:0] dza, dzb;

	assign ax  = $signed(CB'($unsigned(first_x)));
	assign ay  = $signed(CB'($unsigned(first_y)));
	assign bx  = $signed(CB'($unsigned(second_x)));
	assign by  = $signed(CB'($unsigned(second_y)));
	assign dx  = (CB+1)'(bx) - (CB+1)'(ax);
	assign dy  = (CB+1)'(by) - (CB+1)'(ay);
	assign dza = $signed(ZW'(layer)) - $signed(ZW'(CB'(first_z)));
	assign dzb = $signed(ZW'(layer)) - $signed(ZW'(CB'(second_z)));

	logic                 valid_s1;
	logic signed [CB-1:0] ax_s1, ay_s1;
	logic [CB-1:0]        dxm_s1, dym_s1;
	logic                 dxn_s1, dyn_s1;
	logic [DZ-1:0]        dza_s1, dzb_s1;

	always_ff @(posedge clk) begin
		ax_s1  <= ax;
		ay_s1  <= ay;
		dxn_s1 <= dx[CB];
		dyn_s1 <= dy[CB];
		dxm_s1 <= dx[CB] ? CB'(-dx) : CB'(dx);
		dym_s1 <= dy[CB] ? CB'(-dy) : CB'(dy);
		dza_s1 <= dza[ZW-1] ? DZ'(-dza) : DZ'(dza);
		dzb_s1 <= dzb[ZW-1] ? DZ'(-dzb) : DZ'(dzb);
	end

	// stage 2: squares
	logic                 valid_s2;
	logic signed [CB-1:0] ax_s2, ay_s2;
	logic [CB-1:0]        dxm_s2, dym_s2;
	logic                 dxn_s2, dyn_s2;
	logic [2*CB-1:0]      dx2_s2, dy2_s2;
	logic [2*DZ-1:0]      dza2_s2, dzb2_s2;
	logic [ssrp_pkg::KK_W-1:0] kk_s2;
	logic [DZ:0]          kval;

	assign kval = (DZ+1)'(max_height_q) + (DZ+1)'(1);

	always_ff @(posedge clk) begin
		ax_s2   <= ax_s1;
		ay_s2   <= ay_s1;
		dxm_s2  <= dxm_s1;
		dym_s2  <= dym_s1;
		dxn_s2  <= dxn_s1;
		dyn_s2  <= dyn_s1;
		dx2_s2  <= dxm_s1 * dxm_s1;
		dy2_s2  <= dym_s1 * dym_s1;
		dza2_s2 <= dza_s1 * dza_s1;
		dzb2_s2 <= dzb_s1 * dzb_s1;
		kk_s2   <= ssrp_pkg::KK_W'(kval * kval);
	end

	// stage 3: distance and numerator
	logic [D2W-1:0] d2;
	logic [NW-1:0]  num;

	assign d2  = D2W'(dx2_s2) + D2W'(dy2_s2);
	assign num = NW'(d2) + (NW'(kk_s2) - NW'(dza2_s2)) - (NW'(kk_s2) - NW'(dzb2_s2));

	logic                 valid_s3, coinc_s3;
	logic signed [CB-1:0] ax_s3, ay_s3;
	logic [CB-1:0]        dxm_s3, dym_s3;
	logic                 negx_s3, negy_s3;
	logic [D2W-1:0]       d2_s3;
	logic [MW-1:0]        nm_s3;

	always_ff @(posedge clk) begin
		ax_s3    <= ax_s2;
		ay_s3    <= ay_s2;
		dxm_s3   <= dxm_s2;
		dym_s3   <= dym_s2;
		negx_s3  <= num[NW-1] ^ dxn_s2;
		negy_s3  <= num[NW-1] ^ dyn_s2;
		d2_s3    <= d2;
		coinc_s3 <= d2 == '0;
		nm_s3    <= num[NW-1] ? MW'(-num) : MW'(num);
	end

	// stage 4: split products
	logic                 valid_s4, coinc_s4;
	logic signed [CB-1:0] ax_s4, ay_s4;
	logic                 negx_s4, negy_s4;
	logic [D2W-1:0]       d2_s4;
	logic [LO+CB-1:0]     plx_s4, ply_s4;
	logic [HI+CB-1:0]     phx_s4, phy_s4;

	always_ff @(posedge clk) begin
		ax_s4    <= ax_s3;
		ay_s4    <= ay_s3;
		negx_s4  <= negx_s3;
		negy_s4  <= negy_s3;
		d2_s4    <= d2_s3;
		coinc_s4 <= coinc_s3;
		plx_s4   <= nm_s3[LO-1:0] * dxm_s3;
		ply_s4   <= nm_s3[LO-1:0] * dym_s3;
		phx_s4   <= nm_s3[MW-1:LO] * dxm_s3;
		phy_s4   <= nm_s3[MW-1:LO] * dym_s3;
	end

	// stage 5: dividend assembly, first cell inputs
	logic [PW-1:0] nx, ny;

	assign nx = PW'(plx_s4) + (PW'(phx_s4) << LO);
	assign ny = PW'(ply_s4) + (PW'(phy_s4) << LO);

	logic               cv   [QW+1];
	logic               cc   [QW+1];
	logic [DW-1:0]      cd   [QW+1];
	logic [1:0][DW-1:0] crem [QW+1];
	logic [1:0][QW-1:0] cn   [QW+1];
	logic [1:0][QW-1:0] cq   [QW+1];
	logic [1:0]         cneg [QW+1];
	logic [1:0][CB-1:0] cbase[QW+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			cv[0]    <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			cv[0]    <= valid_s4;
		end
	end

	always_ff @(posedge clk) begin
		cc[0]       <= coinc_s4;
		cd[0]       <= DW'({d2_s4, 1'b0});
		crem[0][0]  <= nx[PW-1:QW];
		crem[0][1]  <= ny[PW-1:QW];
		cn[0][0]    <= nx[QW-1:0];
		cn[0][1]    <= ny[QW-1:0];
		cq[0]       <= '0;
		cneg[0]     <= {negy_s4, negx_s4};
		cbase[0][0] <= ax_s4;
		cbase[0][1] <= ay_s4;
	end

	for (genvar i = 0; i < QW; i++) begin : g_cell
		ssrp_div_cell #(
			.DW(DW),
			.QW(QW),
			.CB(CB)
		) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.valid_i(cv[i]),
			.coinc_i(cc[i]),
			.d_i    (cd[i]),
			.rem_i  (crem[i]),
			.n_i    (cn[i]),
			.q_i    (cq[i]),
			.neg_i  (cneg[i]),
			.base_i (cbase[i]),
			.valid_o(cv[i+1]),
			.coinc_o(cc[i+1]),
			.d_o    (cd[i+1]),
			.rem_o  (crem[i+1]),
			.n_o    (cn[i+1]),
			.q_o    (cq[i+1]),
			.neg_o  (cneg[i+1]),
			.base_o (cbase[i+1])
		);
	end

	// output: sign, offset, saturate
	logic signed [SW-1:0] sum [2];
	logic [ssrp_pkg::OUT_W-1:0] sat [2];

	always_comb begin
		for (int l = 0; l < 2; l++) begin
			sum[l] = SW'($signed(cbase[QW][l]))
				+ (cneg[QW][l] ? -$signed(SW'(cq[QW][l])) : $signed(SW'(cq[QW][l])));
			if (sum[l] > SMAX) begin
				sat[l] = ssrp_pkg::SAT_MAX;
			end else if (sum[l] < SMIN) begin
				sat[l] = ssrp_pkg::SAT_MIN;
			end else begin
				sat[l] = sum[l][ssrp_pkg::OUT_W-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= cv[QW];
		end
	end

	always_ff @(posedge clk) begin
		coincident <= cc[QW];
		cross_x    <= cc[QW] ? '0 : $signed(sat[0]);
		cross_y    <= cc[QW] ? '0 : $signed(sat[1]);
	end

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> ##LAT done)
		else $error("result strobe missing after accepted beat");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, LAT))
		else $error("result strobe without accepted beat");

	a_coinc_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && coincident |-> cross_x == '0 && cross_y == '0)
		else $error("coincident result not cleared");

endmodule

// ----- hw/rtl/ssrp_div_cell.sv -----
// ----------------------------------------------------------------------------
// ssrp_div_cell
// One restoring division step for the x and y lanes, registered.
// ----------------------------------------------------------------------------
module ssrp_div_cell #(
	parameter int DW = 34,
	parameter int QW = 34,
	parameter int CB = 16
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      valid_i,
	input  logic                      coinc_i,
	input  logic [DW-1:0]             d_i,
	input  logic [1:0][DW-1:0]        rem_i,
	input  logic [1:0][QW-1:0]        n_i,
	input  logic [1:0][QW-1:0]        q_i,
	input  logic [1:0]                neg_i,
	input  logic [1:0][CB-1:0]        base_i,
	output logic                      valid_o,
	output logic                      coinc_o,
	output logic [DW-1:0]             d_o,
	output logic [1:0][DW-1:0]        rem_o,
	output logic [1:0][QW-1:0]        n_o,
	output logic [1:0][QW-1:0]        q_o,
	output logic [1:0]                neg_o,
	output logic [1:0][CB-1:0]        base_o
);

	logic [1:0][DW:0]   trial;
	logic [1:0][DW:0]   diff;
	logic [1:0]         ge;

	always_comb begin
		for (int l = 0; l < 2; l++) begin
			trial[l] = {rem_i[l], n_i[l][QW-1]};
			ge[l]    = trial[l] >= {1'b0, d_i};
			diff[l]  = trial[l] - {1'b0, d_i};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_o <= 1'b0;
		end else begin
			valid_o <= valid_i;
		end
	end

	always_ff @(posedge clk) begin
		coinc_o <= coinc_i;
		d_o     <= d_i;
		neg_o   <= neg_i;
		base_o  <= base_i;
		for (int l = 0; l < 2; l++) begin
			rem_o[l] <= ge[l] ? diff[l][DW-1:0] : trial[l][DW-1:0];
			n_o[l]   <= {n_i[l][QW-2:0], 1'b0};
			q_o[l]   <= {q_i[l][QW-2:0], ge[l]};
		end
	end

endmodule
